// ----- hdl/srssi_pkg.sv -----
// ----------------------------------------------------------------------------
// srssi_pkg
// shared constants and types of the sorted record store
// ----------------------------------------------------------------------------
package srssi_pkg;
  localparam int unsigned DepthDefault = 64;
  localparam logic [6:0] StrideReset = 7'd5;

  localparam logic [2:0] OpClear  = 3'd0;
  localparam logic [2:0] OpInsert = 3'd1;
  localparam logic [2:0] OpDelete = 3'd2;
  localparam logic [2:0] OpModify = 3'd3;
  localparam logic [2:0] OpSearch = 3'd4;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  typedef struct packed {
    logic [31:0] key;
    logic [63:0] payload;
  } rec_t;
endpackage

// ----- hdl/sorted_record_store_sparse_index_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_record_store_sparse_index_unit
// sorted key/payload table with stable insert, delete, modify and search
// ----------------------------------------------------------------------------
// one word at a time, busy from start until the result strobe
// clear and unused opcodes go straight to the done state; search walks the index
// insert: shifts larger keys up, reading then writing each shifted record
// delete: compacts the table; modify: search + delete-style removal + insert
// rst_ni clears control and count only, the record ram is not cleared
// the receiver cannot stall: done_o is high for one cycle, the results hold until the next start
module sorted_record_store_sparse_index_unit #(
  parameter int unsigned Depth = srssi_pkg::DepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] key_i,
  input  logic [31:0] new_key_i,
  input  logic [63:0] payload_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [63:0] found_payload_o,
  output logic [5:0]  found_position_o,
  output logic [6:0]  record_count_o
);
  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam int unsigned XW = CW + 8;
  localparam logic [CW-1:0] DepthC = CW'(Depth);

  // states
  localparam logic [3:0] SIdle = 4'd0, SIdxRd = 4'd1, SIdxChk = 4'd2,
    SScRd = 4'd3, SScChk = 4'd4, SInsRd = 4'd5, SInsChk = 4'd6,
    SDelRd = 4'd7, SDelChk = 4'd8, SDone = 4'd9, SModRd = 4'd10,
    SModChk = 4'd11, SPayRd = 4'd12, SPayOut = 4'd13;

  logic [3:0] st_q, st_d;
  logic [6:0] stride_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [2:0] op_q;
  logic [31:0] key_q, nkey_q;
  logic [63:0] pay_q;
  logic [CW-1:0] i_q, i_d, w_q, w_d, lb_q, lb_d, ub_q, ub_d;
  logic [1:0] status_q, status_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [63:0] fpay_q, fpay_d;
  logic mod_q, mod_d;  // modify: removing the first match before reinsert
  logic done_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  srssi_pkg::rec_t wdata, rdata;

  srssi_ram #(.Width($bits(srssi_pkg::rec_t)), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  logic [XW-1:0] stride_e;
  assign stride_e = XW'(stride_q);

  // key placed by the insert walk
  logic [31:0] ins_key;
  // modify to a key at or above the old one lands ahead of equal keys
  logic ins_tie;
  assign ins_key = (op_q == srssi_pkg::OpModify) ? nkey_q : key_q;
  assign ins_tie = (op_q == srssi_pkg::OpModify) && ($signed(nkey_q) >= $signed(key_q));

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; i_d = i_q; w_d = w_q; lb_d = lb_q; ub_d = ub_q;
    status_d = status_q; pos_d = pos_q; fpay_d = fpay_q; mod_d = mod_q;
    done_d = 1'b0; we = 1'b0; waddr = w_q[AW-1:0]; raddr = i_q[AW-1:0];
    wdata = rdata;
    case (st_q)
      SIdle: begin
        if (start) begin
          status_d = srssi_pkg::StOk; fpay_d = '0; pos_d = '0; mod_d = 1'b0;
          lb_d = '0; ub_d = cnt_q; w_d = '0;
          case (opcode_i)
            srssi_pkg::OpClear: begin cnt_d = '0; st_d = SDone; end
            srssi_pkg::OpInsert: begin
              if (cnt_q >= DepthC) begin
                status_d = srssi_pkg::StFull; st_d = SDone;
              end else begin
                // shift larger keys up from the top
                i_d = cnt_q; st_d = SInsRd;
              end
            end
            srssi_pkg::OpDelete: begin i_d = '0; st_d = SDelRd; end
            srssi_pkg::OpModify, srssi_pkg::OpSearch: begin
              // no index entry below the fill level: scan the whole table
              if (stride_q == '0 || stride_e > XW'(cnt_q)) begin
                i_d = '0; st_d = SScRd;
              end else begin i_d = CW'(stride_q - 7'd1); st_d = SIdxRd; end
            end
            default: st_d = SDone;
          endcase
        end
      end
      SIdxRd: begin
        if (i_q >= cnt_q) begin
          i_d = lb_q; st_d = SScRd;
        end else st_d = SIdxChk;
      end
      SIdxChk: begin
        if ($signed(key_q) < $signed(rdata.key)) begin
          ub_d = i_q; i_d = lb_q; st_d = SScRd;
        end else begin
          lb_d = i_q;
          if (XW'(i_q) + stride_e >= XW'(cnt_q)) begin
            i_d = i_q; st_d = SScRd;
          end else begin
            i_d = CW'(XW'(i_q) + stride_e); st_d = SIdxRd;
          end
        end
        if (st_d == SScRd) i_d = (ub_d == i_q) ? lb_q : i_q;
      end
      SScRd: begin
        if (i_q > ub_q || i_q >= cnt_q) begin
          status_d = srssi_pkg::StNotFound; st_d = SDone;
        end else st_d = SScChk;
      end
      SScChk: begin
        if (rdata.key == key_q) begin
          if (op_q == srssi_pkg::OpSearch) begin
            pos_d = i_q; fpay_d = rdata.payload; st_d = SDone;
          end else begin
            // remove the first matching record, then insert the new one
            mod_d = 1'b1; i_d = '0; w_d = '0; st_d = SModRd;
          end
        end else begin
          i_d = i_q + 1'b1; st_d = SScRd;
        end
      end
      SModRd: begin
        if (i_q >= cnt_q) begin
          cnt_d = cnt_q - 1'b1; i_d = cnt_q - 1'b1; st_d = SInsRd;
        end else st_d = SModChk;
      end
      SModChk: begin
        if (mod_q && rdata.key == key_q) mod_d = 1'b0;
        else begin
          we = 1'b1; w_d = w_q + 1'b1;
        end
        i_d = i_q + 1'b1; st_d = SModRd;
      end
      SInsRd: begin
        if (i_q == '0) begin
          we = 1'b1; waddr = '0;
          wdata.key = ins_key;
          wdata.payload = pay_q; cnt_d = cnt_q + 1'b1; st_d = SDone;
        end else begin
          raddr = AW'(i_q - 1'b1); st_d = SInsChk;
        end
      end
      SInsChk: begin
        waddr = i_q[AW-1:0];
        if ($signed(ins_key) < $signed(rdata.key)
            || (ins_tie && ins_key == rdata.key)) begin
          we = 1'b1; i_d = i_q - 1'b1; st_d = SInsRd;
        end else begin
          we = 1'b1;
          wdata.key = ins_key;
          wdata.payload = pay_q; cnt_d = cnt_q + 1'b1; st_d = SDone;
        end
      end
      SDelRd: begin
        if (i_q >= cnt_q) begin cnt_d = w_q; st_d = SDone; end
        else st_d = SDelChk;
      end
      SDelChk: begin
        if (rdata.key != key_q) begin we = 1'b1; w_d = w_q + 1'b1; end
        i_d = i_q + 1'b1; st_d = SDelRd;
      end
      SDone: begin done_d = 1'b1; st_d = SIdle; end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; stride_q <= srssi_pkg::StrideReset; cnt_q <= '0;
      done_o <= 1'b0; mod_q <= 1'b0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; done_o <= done_d; mod_q <= mod_d;
      if (cfg_we_i) stride_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; w_q <= w_d; lb_q <= lb_d; ub_q <= ub_d;
    status_q <= status_d; pos_q <= pos_d; fpay_q <= fpay_d;
    if (start && !busy) begin
      op_q <= opcode_i; key_q <= key_i; nkey_q <= new_key_i; pay_q <= payload_i;
    end
  end

  assign busy = (st_q != SIdle);
  assign status_o = status_q;
  assign found_payload_o = fpay_q;
  assign found_position_o = 6'(pos_q);
  assign record_count_o = 7'(cnt_q);

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC) else $error("count overflow");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("double strobe");
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start not taken");
endmodule

// ----- hdl/srssi_ram.sv -----
// ----------------------------------------------------------------------------
// srssi_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module srssi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
